// ===== design/ews_pkg.sv =====
package ews_pkg;

   localparam int LETTER_W = 5;
   localparam int WEIGHT_W = 16;
   localparam int CELL_W   = 24;

   localparam logic [1:0] OP_WRITE_WEIGHT = 2'd0;
   localparam logic [1:0] OP_APPEND_CAND  = 2'd1;
   localparam logic [1:0] OP_APPEND_TYPED = 2'd2;
   localparam logic [1:0] OP_SCORE        = 2'd3;

   localparam logic [2:0] TBL_DELETE      = 3'd0;
   localparam logic [2:0] TBL_INSERT      = 3'd1;
   localparam logic [2:0] TBL_SUBSTITUTE  = 3'd2;
   localparam logic [2:0] TBL_LEAD_DELETE = 3'd3;
   localparam logic [2:0] TBL_LEAD_INSERT = 3'd4;

   localparam logic signed [WEIGHT_W-1:0] WEIGHT_ZERO = 16'sh8000;
   localparam logic signed [CELL_W-1:0]   CELL_MIN    = 24'sh800000;
   localparam logic signed [CELL_W-1:0]   CELL_MAX    = 24'sh7fffff;

   typedef struct packed {
      logic [1:0]                 opcode;
      logic [2:0]                 weight_table;
      logic [LETTER_W-1:0]        candidate_letter_index;
      logic [LETTER_W-1:0]        typed_letter_index;
      logic signed [WEIGHT_W-1:0] weight;
      logic [LETTER_W-1:0]        letter;
   } req_type;

   typedef struct packed {
      logic signed [CELL_W-1:0] score;
      logic                     overflow;
   } rsp_type;

   typedef struct packed {
      logic                       en;
      logic [2:0]                 table_sel;
      logic [LETTER_W-1:0]        ci;
      logic [LETTER_W-1:0]        ti;
      logic signed [WEIGHT_W-1:0] weight;
   } wt_wr_type;

   typedef struct packed {
      logic                en;
      logic                typed;
      logic [LETTER_W-1:0] letter;
   } append_type;

   typedef struct packed {
      logic signed [WEIGHT_W-1:0] del;
      logic signed [WEIGHT_W-1:0] ins;
      logic signed [WEIGHT_W-1:0] sub;
      logic signed [WEIGHT_W-1:0] lead_del;
      logic signed [WEIGHT_W-1:0] lead_ins;
   } wt_rd_type;

   function automatic logic signed [CELL_W-1:0] sat_add(
      input logic signed [CELL_W-1:0]   acc,
      input logic signed [WEIGHT_W-1:0] w
   );
      logic signed [CELL_W:0] s;
      s = $signed({acc[CELL_W-1], acc}) +
          $signed({{(CELL_W+1-WEIGHT_W){w[WEIGHT_W-1]}}, w});
      if (acc == CELL_MIN || w == WEIGHT_ZERO) begin
         return CELL_MIN;
      end else if (s <= $signed({CELL_MIN[CELL_W-1], CELL_MIN})) begin
         return CELL_MIN;
      end else if (s > $signed({1'b0, CELL_MAX})) begin
         return CELL_MAX;
      end
      return s[CELL_W-1:0];
   endfunction

endpackage

// ===== design/ews_weight_store.sv =====
module ews_weight_store import ews_pkg::*; #(
   parameter int ALPHABET = 26
) (
   input  logic                                        clock,
   input  wt_wr_type                                   wr,
   input  logic [$clog2(ALPHABET*ALPHABET)-1:0]        pair_addr,
   input  logic [LETTER_W-1:0]                         edge_letter,
   output wt_rd_type                                   rd
);
   localparam int WA = $clog2(ALPHABET*ALPHABET);
   localparam int EA = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

   logic signed [WEIGHT_W-1:0] del_mem [ALPHABET*ALPHABET];
   logic signed [WEIGHT_W-1:0] ins_mem [ALPHABET*ALPHABET];
   logic signed [WEIGHT_W-1:0] sub_mem [ALPHABET*ALPHABET];
   logic signed [WEIGHT_W-1:0] ld_mem  [ALPHABET];
   logic signed [WEIGHT_W-1:0] li_mem  [ALPHABET];

   logic [WA-1:0] wr_pair;
   logic          ci_ok;
   logic          ti_ok;

   assign wr_pair = WA'(wr.ci) * WA'(ALPHABET) + WA'(wr.ti);
   assign ci_ok   = int'(wr.ci) < ALPHABET;
   assign ti_ok   = int'(wr.ti) < ALPHABET;

   always_ff @(posedge clock) begin
      if (wr.en && ci_ok) begin
         case (wr.table_sel)
            TBL_DELETE:      if (ti_ok) del_mem[wr_pair] <= wr.weight;
            TBL_INSERT:      if (ti_ok) ins_mem[wr_pair] <= wr.weight;
            TBL_SUBSTITUTE:  if (ti_ok) sub_mem[wr_pair] <= wr.weight;
            TBL_LEAD_DELETE: ld_mem[wr.ci[EA-1:0]] <= wr.weight;
            TBL_LEAD_INSERT: li_mem[wr.ci[EA-1:0]] <= wr.weight;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rd.del      <= del_mem[pair_addr];
      rd.ins      <= ins_mem[pair_addr];
      rd.sub      <= sub_mem[pair_addr];
      rd.lead_del <= ld_mem[edge_letter[EA-1:0]];
      rd.lead_ins <= li_mem[edge_letter[EA-1:0]];
   end
endmodule

// ===== design/ews_word_store.sv =====
module ews_word_store import ews_pkg::*; #(
   parameter int MAX_LEN  = 32,
   parameter int ALPHABET = 26
) (
   input  logic                             clock,
   input  logic                             reset,
   input  append_type                       app,
   input  logic                             clear,
   input  logic [$clog2(MAX_LEN)-1:0]       cand_addr,
   input  logic [$clog2(MAX_LEN)-1:0]       typed_addr,
   output logic [LETTER_W-1:0]              cand_q,
   output logic [LETTER_W-1:0]              typed_q,
   output logic [$clog2(MAX_LEN+1)-1:0]     cand_len,
   output logic [$clog2(MAX_LEN+1)-1:0]     typed_len,
   output logic                             overflow
);
   localparam int AW = $clog2(MAX_LEN);
   localparam int LW = $clog2(MAX_LEN+1);

   logic [LETTER_W-1:0] cand_mem  [MAX_LEN];
   logic [LETTER_W-1:0] typed_mem [MAX_LEN];

   logic [LW-1:0] cand_len_ff, cand_len_in;
   logic [LW-1:0] typed_len_ff, typed_len_in;
   logic          overflow_ff, overflow_in;
   logic          letter_ok;
   logic [LW-1:0] sel_len;
   logic          full;

   assign letter_ok = int'(app.letter) < ALPHABET;
   assign sel_len   = app.typed ? typed_len_ff : cand_len_ff;
   assign full      = sel_len >= LW'(MAX_LEN);

   always_comb begin
      cand_len_in  = cand_len_ff;
      typed_len_in = typed_len_ff;
      overflow_in  = overflow_ff;
      if (clear) begin
         cand_len_in  = '0;
         typed_len_in = '0;
         overflow_in  = 1'b0;
      end else if (app.en && letter_ok) begin
         if (full) begin
            overflow_in = 1'b1;
         end else if (app.typed) begin
            typed_len_in = typed_len_ff + 1'b1;
         end else begin
            cand_len_in = cand_len_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_len_ff  <= '0;
         typed_len_ff <= '0;
         overflow_ff  <= 1'b0;
      end else begin
         cand_len_ff  <= cand_len_in;
         typed_len_ff <= typed_len_in;
         overflow_ff  <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (app.en && letter_ok && !full) begin
         if (app.typed) begin
            typed_mem[sel_len[AW-1:0]] <= app.letter;
         end else begin
            cand_mem[sel_len[AW-1:0]] <= app.letter;
         end
      end
      cand_q  <= cand_mem[cand_addr];
      typed_q <= typed_mem[typed_addr];
   end

   assign cand_len  = cand_len_ff;
   assign typed_len = typed_len_ff;
   assign overflow  = overflow_ff;
endmodule

// ===== design/ews_row_store.sv =====
module ews_row_store import ews_pkg::*; #(
   parameter int MAX_LEN = 32
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [$clog2(MAX_LEN+1)-1:0]       wr_addr,
   input  logic signed [CELL_W-1:0]           wr_data,
   input  logic [$clog2(MAX_LEN+1)-1:0]       rd_addr,
   output logic signed [CELL_W-1:0]           rd_q
);
   logic signed [CELL_W-1:0] row_mem [MAX_LEN+1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
      rd_q <= row_mem[rd_addr];
   end
endmodule

// ===== design/weighted_edit_score.sv =====
// A score request walks the lattice for candidate length C and typed length T; each
// lattice cell needs a candidate-letter read, a dependent weight read and a row-memory
// write, one after another. Weight writes and appends take effect when accepted.
// Throughput: one request at a time; a finished score waits in the output register.
// Reset clears word lengths, overflow flag, sequencer and output valid; weight
// tables and words stay undefined until written.
module weighted_edit_score import ews_pkg::*; #(
   parameter int MAX_LEN  = 32,
   parameter int ALPHABET = 26
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int AW = $clog2(MAX_LEN);
   localparam int LW = $clog2(MAX_LEN+1);
   localparam int WA = $clog2(ALPHABET*ALPHABET);

   typedef enum logic [9:0] {
      S_IDLE      = 10'b0000000001,
      S_INIT_RD   = 10'b0000000010,
      S_INIT_EDGE = 10'b0000000100,
      S_INIT_WR   = 10'b0000001000,
      S_ROW_RD    = 10'b0000010000,
      S_ROW_EDGE  = 10'b0000100000,
      S_ROW_WR0   = 10'b0001000000,
      S_CELL_RD   = 10'b0010000000,
      S_CELL_WT   = 10'b0100000000,
      S_CELL_CALC = 10'b1000000000
   } state_type;

   // score readout reuses the idle code space via a separate flag
   state_type state_ff, state_in;
   logic      fin_ff, fin_in;
   logic      fin_rd_ff, fin_rd_in;

   logic [LW-1:0]             x_ff, x_in;
   logic [LW-1:0]             y_ff, y_in;
   logic [LETTER_W-1:0]       t_ff, t_in;
   logic [LETTER_W-1:0]       c_ff, c_in;
   logic signed [CELL_W-1:0]  diag_ff, diag_in;
   logic signed [CELL_W-1:0]  up_ff, up_in;
   logic signed [CELL_W-1:0]  left_ff, left_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   wt_wr_type                 wt_wr;
   wt_rd_type                 wt_rd;
   logic [WA-1:0]             pair_addr;
   logic [LETTER_W-1:0]       edge_letter;
   append_type                app;
   logic                      clear;
   logic [AW-1:0]             cand_addr, typed_addr;
   logic [LETTER_W-1:0]       cand_q, typed_q;
   logic [LW-1:0]             cand_len, typed_len;
   logic                      overflow;
   logic                      row_wr_en;
   logic [LW-1:0]             row_wr_addr, row_rd_addr;
   logic signed [CELL_W-1:0]  row_wr_data, row_q;

   logic                      accept;
   logic                      out_free;
   logic signed [CELL_W-1:0]  diag_val, ins_val, del_val, best;

   assign req_ready = (state_ff == S_IDLE) && !fin_ff && !fin_rd_ff;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign wt_wr.en        = accept && (req_data.opcode == OP_WRITE_WEIGHT);
   assign wt_wr.table_sel = req_data.weight_table;
   assign wt_wr.ci        = req_data.candidate_letter_index;
   assign wt_wr.ti        = req_data.typed_letter_index;
   assign wt_wr.weight    = req_data.weight;

   assign app.en     = accept && (req_data.opcode == OP_APPEND_CAND ||
                                  req_data.opcode == OP_APPEND_TYPED);
   assign app.typed  = req_data.opcode == OP_APPEND_TYPED;
   assign app.letter = req_data.letter;

   assign clear = fin_ff && out_free;

   // cell arithmetic
   assign diag_val = (c_ff == t_ff) ? diag_ff : sat_add(diag_ff, wt_rd.sub);
   assign ins_val  = sat_add(up_ff, wt_rd.ins);
   assign del_val  = sat_add(left_ff, wt_rd.del);

   always_comb begin
      best = diag_val;
      if (best < ins_val) begin
         best = ins_val;
      end
      if (best < del_val) begin
         best = del_val;
      end
   end

   // memory addressing
   always_comb begin
      cand_addr   = AW'(y_ff - 1'b1);
      typed_addr  = AW'(x_ff - 1'b1);
      row_rd_addr = '0;
      pair_addr   = WA'(cand_q) * WA'(ALPHABET) + WA'(t_ff);
      edge_letter = (state_ff == S_ROW_EDGE) ? typed_q : cand_q;
      row_wr_en   = 1'b0;
      row_wr_addr = '0;
      row_wr_data = '0;
      case (state_ff)
         S_CELL_RD: row_rd_addr = y_ff;
         S_IDLE: begin
            row_rd_addr = cand_len;
            if (accept && req_data.opcode == OP_SCORE) begin
               row_wr_en = 1'b1;
            end
         end
         S_INIT_WR: begin
            row_wr_en   = 1'b1;
            row_wr_addr = y_ff;
            row_wr_data = CELL_W'(wt_rd.lead_del);
         end
         S_ROW_WR0: begin
            row_wr_en   = 1'b1;
            row_wr_data = CELL_W'(wt_rd.lead_ins);
         end
         S_CELL_CALC: begin
            row_wr_en   = 1'b1;
            row_wr_addr = y_ff;
            row_wr_data = best;
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      fin_in       = fin_ff;
      fin_rd_in    = 1'b0;
      x_in         = x_ff;
      y_in         = y_ff;
      t_in         = t_ff;
      c_in         = c_ff;
      diag_in      = diag_ff;
      up_in        = up_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (fin_rd_ff) begin
               fin_in = 1'b1;
            end else if (fin_ff) begin
               if (out_free) begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.score    = row_q;
                  rsp_data_in.overflow = overflow;
                  fin_in               = 1'b0;
               end
            end else if (accept && req_data.opcode == OP_SCORE) begin
               y_in = LW'(1);
               x_in = LW'(1);
               if (cand_len != '0) begin
                  state_in = S_INIT_RD;
               end else if (typed_len != '0) begin
                  state_in = S_ROW_RD;
               end else begin
                  fin_rd_in = 1'b1;
               end
            end
         end
         S_INIT_RD:   state_in = S_INIT_EDGE;
         S_INIT_EDGE: state_in = S_INIT_WR;
         S_INIT_WR: begin
            if (y_ff == cand_len) begin
               x_in = LW'(1);
               if (typed_len != '0) begin
                  state_in = S_ROW_RD;
               end else begin
                  state_in  = S_IDLE;
                  fin_rd_in = 1'b1;
               end
            end else begin
               y_in     = y_ff + 1'b1;
               state_in = S_INIT_RD;
            end
         end
         S_ROW_RD: state_in = S_ROW_EDGE;
         S_ROW_EDGE: begin
            t_in     = typed_q;
            diag_in  = row_q;
            state_in = S_ROW_WR0;
         end
         S_ROW_WR0: begin
            left_in = CELL_W'(wt_rd.lead_ins);
            y_in    = LW'(1);
            if (cand_len != '0) begin
               state_in = S_CELL_RD;
            end else if (x_ff == typed_len) begin
               state_in  = S_IDLE;
               fin_rd_in = 1'b1;
            end else begin
               x_in     = x_ff + 1'b1;
               state_in = S_ROW_RD;
            end
         end
         S_CELL_RD: state_in = S_CELL_WT;
         S_CELL_WT: begin
            c_in     = cand_q;
            up_in    = row_q;
            state_in = S_CELL_CALC;
         end
         S_CELL_CALC: begin
            left_in = best;
            diag_in = up_ff;
            if (y_ff != cand_len) begin
               y_in     = y_ff + 1'b1;
               state_in = S_CELL_RD;
            end else if (x_ff == typed_len) begin
               state_in  = S_IDLE;
               fin_rd_in = 1'b1;
            end else begin
               x_in     = x_ff + 1'b1;
               state_in = S_ROW_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fin_ff       <= 1'b0;
         fin_rd_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fin_ff       <= fin_in;
         fin_rd_ff    <= fin_rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      t_ff        <= t_in;
      c_ff        <= c_in;
      diag_ff     <= diag_in;
      up_ff       <= up_in;
      left_ff     <= left_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   ews_weight_store #(.ALPHABET(ALPHABET)) u_weights (
      .clock       (clock),
      .wr          (wt_wr),
      .pair_addr   (pair_addr),
      .edge_letter (edge_letter),
      .rd          (wt_rd)
   );

   ews_word_store #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_words (
      .clock      (clock),
      .reset      (reset),
      .app        (app),
      .clear      (clear),
      .cand_addr  (cand_addr),
      .typed_addr (typed_addr),
      .cand_q     (cand_q),
      .typed_q    (typed_q),
      .cand_len   (cand_len),
      .typed_len  (typed_len),
      .overflow   (overflow)
   );

   ews_row_store #(.MAX_LEN(MAX_LEN)) u_row (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (row_wr_data),
      .rd_addr (row_rd_addr),
      .rd_q    (row_q)
   );

   a_cell_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CELL_CALC |-> (y_ff != '0 && y_ff <= cand_len && x_ff <= typed_len))
      else $error("lattice cell index beyond word length");

   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_clear_on_result: assert property (@(posedge clock) disable iff (reset)
      clear |=> (cand_len == '0 && typed_len == '0 && !overflow))
      else $error("words not cleared after score");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready)
      else $error("request taken while scoring");
endmodule
